// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the timestamp pair matcher modules.
// Depends on nothing; each macro takes its own clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tpm_pkg.sv -----
// Package of the timestamp pair matcher: sizes, word types, list control and states.
// Depends on nothing; the slot list and the top level refer to it by scoped names.
`default_nettype none

package tpm_pkg;

    localparam int BUFFER_DEPTH = 7;
    localparam int COUNT_W      = $clog2(BUFFER_DEPTH + 1);
    localparam int SLOT_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int ADDR_W       = SLOT_W + 1;

    localparam int TIME_W = 63;
    localparam int POS_W  = 32;
    localparam int WIN_W  = 30;

    localparam logic [WIN_W-1:0] WIN_RESET = 30'd71400000;

    localparam logic MODE_CAMERA = 1'b0;
    localparam logic MODE_ROBOT  = 1'b1;

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [SLOT_W-1:0]  t_slot;
    typedef t_slot [BUFFER_DEPTH-1:0] t_ord;

    typedef struct packed {
        logic                    mode;
        logic [TIME_W-1:0]       sample_time;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_in_word;

    typedef struct packed {
        logic [TIME_W-1:0]       camera_time;
        logic signed [POS_W-1:0] camera_x;
        logic signed [POS_W-1:0] camera_y;
        logic signed [POS_W-1:0] camera_z;
        logic [TIME_W-1:0]       robot_time;
        logic signed [POS_W-1:0] robot_x;
        logic signed [POS_W-1:0] robot_y;
        logic signed [POS_W-1:0] robot_z;
    } t_out_word;

    typedef struct packed {
        logic [TIME_W-1:0]       stamp;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic  clamp;
        logic  push;
        logic  remove;
        t_slot idx;
    } t_list_ctl;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_STORE = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/tpm_sample_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing; holds the stored samples of both buffers.
`default_nettype none

module tpm_sample_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tpm_slot_list.sv -----
// Newest-first order of RAM slots for one buffer, with its fill count.
// Depends on tpm_pkg and assert_macros.svh; the order is always a permutation of all slots.
`default_nettype none
`include "assert_macros.svh"

module tpm_slot_list (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tpm_pkg::t_list_ctl i_ctl,
    output tpm_pkg::t_count        o_count,
    output tpm_pkg::t_ord          o_ord
);

    localparam int D = tpm_pkg::BUFFER_DEPTH;

    tpm_pkg::t_count r_count, n_count, cnt_m1;
    tpm_pkg::t_ord   r_ord, n_ord;
    tpm_pkg::t_slot  free_slot, rem_slot;
    tpm_pkg::t_slot  prev_w [D];
    tpm_pkg::t_slot  next_w [D];

    assign cnt_m1    = r_count - tpm_pkg::COUNT_W'(1);
    assign free_slot = r_ord[r_count[tpm_pkg::SLOT_W-1:0]];
    assign rem_slot  = r_ord[i_ctl.idx];

    for (genvar k = 0; k < D; k++) begin : g_ord
        if (k == 0) begin : g_first
            assign prev_w[k] = free_slot;
        end else begin : g_prev
            assign prev_w[k] = r_ord[k-1];
        end
        if (k == D - 1) begin : g_last
            assign next_w[k] = rem_slot;
        end else begin : g_next
            assign next_w[k] = r_ord[k+1];
        end
    end

    always_comb begin
        n_ord = r_ord;
        for (int k = 0; k < D; k++) begin
            if (i_ctl.push) begin
                if (tpm_pkg::COUNT_W'(k) <= r_count) begin
                    n_ord[k] = prev_w[k];
                end
            end else if (i_ctl.remove) begin
                if (tpm_pkg::COUNT_W'(k) >= tpm_pkg::COUNT_W'(i_ctl.idx)) begin
                    if (tpm_pkg::COUNT_W'(k) < cnt_m1) begin
                        n_ord[k] = next_w[k];
                    end else if (tpm_pkg::COUNT_W'(k) == cnt_m1) begin
                        n_ord[k] = rem_slot;
                    end
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_ctl.clamp && r_count == tpm_pkg::COUNT_W'(D)) begin
            n_count = tpm_pkg::COUNT_W'(D - 1);
        end else if (i_ctl.push) begin
            n_count = r_count + tpm_pkg::COUNT_W'(1);
        end else if (i_ctl.remove) begin
            n_count = cnt_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int k = 0; k < D; k++) begin
                r_ord[k] <= tpm_pkg::SLOT_W'(k);
            end
        end else begin
            r_count <= n_count;
            r_ord   <= n_ord;
        end
    end

    assign o_count = r_count;
    assign o_ord   = r_ord;

    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n,
        r_count <= tpm_pkg::COUNT_W'(D), "count overflow")
    `ASSERT_IMPLIES(a_push_room, i_clk, i_rst_n, i_ctl.push,
        r_count < tpm_pkg::COUNT_W'(D), "push into full list")
    `ASSERT_IMPLIES(a_remove_live, i_clk, i_rst_n, i_ctl.remove,
        tpm_pkg::COUNT_W'(i_ctl.idx) < r_count, "remove of dead entry")
    `ASSERT_ALWAYS(a_one_op, i_clk, i_rst_n,
        $onehot0({i_ctl.clamp, i_ctl.push, i_ctl.remove}), "list operations overlap")

endmodule

`default_nettype wire

// ----- hdl/timestamp_pair_matcher.sv -----
// Top level of the timestamp pair matcher: sequencer, window compare and output register.
// Depends on tpm_pkg, tpm_sample_ram, tpm_slot_list and assert_macros.svh.
//
//  channel  direction  handshake                  word
//  in       input      i_in_valid / o_in_ready    i_in_word  (tpm_pkg::t_in_word)
//  out      output     o_out_valid / i_out_ready  o_out_word (tpm_pkg::t_out_word)
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_data (match_window_ns)
//
// Each sample is accepted, then stored entries of the other buffer are read from the sample RAM
// in turn until a partner is found, and then the sample is stored or the pair is emitted.
// The RAM read port scans one entry a cycle, and only one sample is in work at a time.
// Reset is synchronous and leaves both buffers empty and the window at 71400000 ns.
// A pair waits for the output register to drain, and input is held off while it waits.
`default_nettype none
`include "assert_macros.svh"

module timestamp_pair_matcher (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire tpm_pkg::t_in_word          i_in_word,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output tpm_pkg::t_out_word              o_out_word,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [tpm_pkg::WIN_W-1:0]  i_cfg_data
);

    localparam int CMP_W = tpm_pkg::COUNT_W + 1;

    tpm_pkg::t_state    r_state, n_state;
    logic               r_sel, n_sel;
    tpm_pkg::t_entry    r_sample, n_sample;
    tpm_pkg::t_entry    r_partner, n_partner;
    tpm_pkg::t_slot     r_j, n_j;
    tpm_pkg::t_slot     r_hit_j, n_hit_j;
    logic               r_out_valid, n_out_valid;
    tpm_pkg::t_out_word r_out_word, n_out_word;
    logic [tpm_pkg::WIN_W-1:0] r_window;

    tpm_pkg::t_list_ctl ctl [2];
    tpm_pkg::t_count    cnt [2];
    tpm_pkg::t_ord      ord [2];

    logic                        rd_en, wr_en;
    logic [tpm_pkg::ADDR_W-1:0]  rd_addr, wr_addr;
    tpm_pkg::t_entry             rd_data;
    logic [tpm_pkg::ENTRY_W-1:0] rd_bits;

    logic                        in_acc, out_free, hit, more;
    logic [tpm_pkg::TIME_W-1:0]  diff;
    tpm_pkg::t_count             other_cnt;
    tpm_pkg::t_slot              j_next;

    tpm_slot_list u_list_cam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl[0]),
        .o_count (cnt[0]),
        .o_ord   (ord[0])
    );

    tpm_slot_list u_list_rob (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl[1]),
        .o_count (cnt[1]),
        .o_ord   (ord[1])
    );

    tpm_sample_ram #(
        .ADDR_W (tpm_pkg::ADDR_W),
        .DATA_W (tpm_pkg::ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_sample),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_bits)
    );

    assign rd_data = tpm_pkg::t_entry'(rd_bits);

    assign o_in_ready  = (r_state == tpm_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign other_cnt   = cnt[!r_sel];
    assign j_next      = r_j + tpm_pkg::SLOT_W'(1);
    assign more        = (CMP_W'(r_j) + CMP_W'(1)) < CMP_W'(other_cnt);

    assign diff = (rd_data.stamp > r_sample.stamp) ? (rd_data.stamp - r_sample.stamp)
                                                   : (r_sample.stamp - rd_data.stamp);
    assign hit  = diff < tpm_pkg::TIME_W'(r_window);

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_sample    = r_sample;
        n_partner   = r_partner;
        n_j         = r_j;
        n_hit_j     = r_hit_j;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        ctl[0]      = '0;
        ctl[1]      = '0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = {r_sel, ord[r_sel][cnt[r_sel][tpm_pkg::SLOT_W-1:0]]};

        unique case (r_state)
            tpm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_sel                = i_in_word.mode;
                    n_sample.stamp       = i_in_word.sample_time;
                    n_sample.pos_x       = i_in_word.pos_x;
                    n_sample.pos_y       = i_in_word.pos_y;
                    n_sample.pos_z       = i_in_word.pos_z;
                    ctl[i_in_word.mode].clamp = 1'b1;
                    n_j                  = '0;
                    rd_addr              = {!i_in_word.mode, ord[!i_in_word.mode][0]};
                    if (cnt[!i_in_word.mode] == '0) begin
                        n_state = tpm_pkg::ST_STORE;
                    end else begin
                        rd_en   = 1'b1;
                        n_state = tpm_pkg::ST_SCAN;
                    end
                end
            end
            tpm_pkg::ST_SCAN: begin
                rd_addr = {!r_sel, ord[!r_sel][j_next]};
                if (hit) begin
                    n_partner = rd_data;
                    n_hit_j   = r_j;
                    n_state   = tpm_pkg::ST_EMIT;
                end else if (more) begin
                    rd_en   = 1'b1;
                    n_j     = j_next;
                end else begin
                    n_state = tpm_pkg::ST_STORE;
                end
            end
            tpm_pkg::ST_STORE: begin
                wr_en             = 1'b1;
                ctl[r_sel].push   = 1'b1;
                n_state           = tpm_pkg::ST_IDLE;
            end
            tpm_pkg::ST_EMIT: begin
                if (out_free) begin
                    ctl[!r_sel].remove = 1'b1;
                    ctl[!r_sel].idx    = r_hit_j;
                    n_out_valid        = 1'b1;
                    if (r_sel == tpm_pkg::MODE_CAMERA) begin
                        n_out_word = {r_sample.stamp, r_sample.pos_x, r_sample.pos_y,
                                      r_sample.pos_z, r_partner.stamp, r_partner.pos_x,
                                      r_partner.pos_y, r_partner.pos_z};
                    end else begin
                        n_out_word = {r_partner.stamp, r_partner.pos_x, r_partner.pos_y,
                                      r_partner.pos_z, r_sample.stamp, r_sample.pos_x,
                                      r_sample.pos_y, r_sample.pos_z};
                    end
                    n_state = tpm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tpm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_window    <= tpm_pkg::WIN_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_window <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel      <= n_sel;
        r_sample   <= n_sample;
        r_partner  <= n_partner;
        r_j        <= n_j;
        r_hit_j    <= n_hit_j;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_acc,
        r_state != tpm_pkg::ST_IDLE, "accept left sequencer idle")
    `ASSERT_IMPLIES(a_scan_live, i_clk, i_rst_n, r_state == tpm_pkg::ST_SCAN,
        tpm_pkg::COUNT_W'(r_j) < other_cnt, "scan past live entries")
    `ASSERT_IMPLIES(a_store_room, i_clk, i_rst_n, r_state == tpm_pkg::ST_STORE,
        cnt[r_sel] < tpm_pkg::COUNT_W'(tpm_pkg::BUFFER_DEPTH), "store into unclamped buffer")

endmodule

`default_nettype wire
